// File: hdl/line_resampler_interp_assert.svh
// Assertion macros for the line resampler.
// Uses i_clk and i_rst_n of the including module; empty under SYNTHESIS.
`ifndef LINE_RESAMPLER_INTERP_ASSERT_SVH
`define LINE_RESAMPLER_INTERP_ASSERT_SVH

`ifndef SYNTHESIS
// check an implication in the same cycle
`define LRI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// check an implication in the next cycle
`define LRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRI_ASSERT_NOW(lbl, ante, cons, msg)
`define LRI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/lri_pkg.sv
// Package for the line resampler: defaults, register indexes, method codes.
// No dependencies.
`timescale 1ns / 1ps
package lri_pkg;

    localparam int LINE_MAX_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WBITS         = 18;

    localparam logic [10:0] LINE_LENGTH_RST = 11'd512;
    localparam logic [19:0] STEP_RATIO_RST  = 20'd65536;

    typedef enum logic [1:0] {
        CFG_LINE_LENGTH = 2'd0,
        CFG_STEP_RATIO  = 2'd1,
        CFG_METHOD      = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MTH_NEAREST   = 2'd0,
        MTH_LINEAR    = 2'd1,
        MTH_CUBIC     = 2'd2,
        MTH_CUBIC_ALT = 2'd3
    } t_method;

endpackage

// File: hdl/line_resampler_interp.sv
// Line resampler: one pass of a separable scaler, nearest / linear / cubic (a = -0.5).
// Depends on lri_pkg and line_resampler_interp_assert.svh.
`timescale 1ns / 1ps
// Takes one word per clock unless o_in_stall is high, writes and requests alike, and
// returns one sample per request. Source pixels live in two copies of the line
// store, each read at two addresses, so the four cubic neighbours come in one access.
// Position k*step is formed in the accept cycle; t^2 and t^3 go through two multiply
// stages, then weights, products and the rounded, saturated sum. A two-deep output
// register lets the pipeline run on while the consumer stalls; o_in_stall rises only
// once both are full. No clearing pass after reset: unwritten pixels read as garbage.
module line_resampler_interp #(
    parameter int LINE_MAX  = lri_pkg::LINE_MAX_DEF,
    parameter int FRAC_BITS = lri_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [9:0]  i_pixel_index,
    input  logic [7:0]  i_pixel_value,
    input  logic [11:0] i_sample_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_sample_value,
    output logic [11:0] o_sample_number,
    output logic        o_clipped
);
    import lri_pkg::*;

`include "line_resampler_interp_assert.svh"

    localparam int AW = $clog2(LINE_MAX);
    localparam int NW = $clog2(LINE_MAX + 1);
    localparam int LW = (NW > 11) ? NW : 11;
    localparam int IW = 32 - FRAC_BITS;
    localparam int CW = (IW > NW) ? IW : NW;
    localparam int SW = AW + 2;

    localparam logic signed [58:0] C_2T3  = 59'sh80000000000000;
    localparam logic signed [58:0] C_HALF = 59'sh1000000000;
    localparam logic signed [19:0] C_WONE = 20'sd262144;
    localparam logic signed [30:0] C_RND  = 31'sd131072;

    // configuration
    logic [10:0] r_line_length;
    logic [19:0] r_step_ratio;
    t_method     r_method;
    t_cfg_idx    cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RST;
            r_step_ratio  <= STEP_RATIO_RST;
            r_method      <= MTH_CUBIC;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[10:0];
                CFG_STEP_RATIO:  r_step_ratio  <= i_cfg_data;
                CFG_METHOD:      r_method      <= t_method'(i_cfg_data[1:0]);
                default:         ;
            endcase
        end
    end

    // effective length, clamped into 4..LINE_MAX
    logic [LW-1:0] len_ext;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_m1;
    always_comb begin
        len_ext = LW'(r_line_length);
        if (len_ext < LW'(4))
            n_eff = NW'(4);
        else if (len_ext > LW'(LINE_MAX))
            n_eff = NW'(LINE_MAX);
        else
            n_eff = len_ext[NW-1:0];
        n_m1 = n_eff - NW'(1);
    end

    // pipeline control
    logic r_skid_v;
    logic en;
    logic in_accept;
    assign en         = !r_skid_v;
    assign o_in_stall = r_skid_v;
    assign in_accept  = i_in_valid && !o_in_stall;

    // stage A: position
    logic        r_a_v;
    logic [11:0] r_a_k;
    logic [31:0] r_a_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_a_v <= 1'b0;
        else if (en)
            r_a_v <= in_accept && i_mode;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_k   <= i_sample_index;
            r_a_pos <= 32'(i_sample_index) * 32'(r_step_ratio);
        end
    end

    // stage B: base, phase, neighbour addresses
    logic [IW-1:0]        pos_int;
    logic [FRAC_BITS-1:0] pos_frac;
    logic [17:0]          t_raw;
    logic [17:0]          t_b;
    logic [AW-1:0]        base;
    logic [AW-1:0]        addr [4];

    assign pos_int  = r_a_pos[31:FRAC_BITS];
    assign pos_frac = r_a_pos[FRAC_BITS-1:0];

    generate
        if (FRAC_BITS >= WBITS) begin : g_frac_cut
            assign t_raw = pos_frac[FRAC_BITS-1 -: WBITS];
        end else begin : g_frac_pad
            assign t_raw = {pos_frac, {(WBITS - FRAC_BITS){1'b0}}};
        end
    endgenerate

    function automatic logic [AW-1:0] mirror(input logic [AW-1:0] b,
                                             input logic signed [SW-1:0] d,
                                             input logic [NW-1:0] nm1);
        logic signed [SW-1:0] j;
        logic signed [SW-1:0] top;
        begin
            j   = $signed({2'b00, b}) + d;
            top = $signed(SW'(nm1));
            if (j < 0)
                j = -j;
            else if (j > top)
                j = (top <<< 1) - j;
            return j[AW-1:0];
        end
    endfunction

    always_comb begin
        logic [CW-1:0] i_ext;
        i_ext = CW'(pos_int);
        if (i_ext >= CW'(n_eff)) begin
            base = n_m1[AW-1:0];
            t_b  = '0;
        end else begin
            base = i_ext[AW-1:0];
            t_b  = t_raw;
        end
        addr[0] = mirror(base, -SW'(1), n_m1);
        addr[1] = mirror(base, SW'(0), n_m1);
        addr[2] = mirror(base, SW'(1), n_m1);
        addr[3] = mirror(base, SW'(2), n_m1);
    end

    // line store, two copies with two read ports each
    logic [7:0] mem_lo [LINE_MAX];
    logic [7:0] mem_hi [LINE_MAX];
    logic [7:0] r_c_px [4];
    logic       wr_en;
    logic [AW-1:0] wr_addr;

    assign wr_en   = in_accept && !i_mode && (32'(i_pixel_index) < 32'(LINE_MAX));
    assign wr_addr = AW'(i_pixel_index);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_lo[wr_addr] <= i_pixel_value;
            mem_hi[wr_addr] <= i_pixel_value;
        end
        if (en) begin
            r_c_px[0] <= mem_lo[addr[0]];
            r_c_px[1] <= mem_lo[addr[1]];
            r_c_px[2] <= mem_hi[addr[2]];
            r_c_px[3] <= mem_hi[addr[3]];
        end
    end

    // stage C: t^2
    logic        r_c_v;
    logic [11:0] r_c_k;
    logic [17:0] r_c_t;
    logic [17:0] r_b_t;
    logic [11:0] r_b_k;
    logic        r_b_v;
    logic [35:0] r_c_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    // stage B register sits alongside the memory read, stage C squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_t  <= t_b;
            r_b_k  <= r_a_k;
            r_c_t  <= r_b_t;
            r_c_k  <= r_b_k;
            r_c_t2 <= 36'(r_b_t) * 36'(r_b_t);
        end
    end

    // hold the pixels in an extra register so they line up with t^2
    logic [7:0] r_cc_px [4];

    // stage D: t^3 as two partial products
    logic        r_d_v;
    logic [11:0] r_d_k;
    logic [17:0] r_d_t;
    logic [35:0] r_d_t2;
    logic [35:0] r_d_hi;
    logic [35:0] r_d_lo;
    logic [7:0]  r_d_px [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_d_v <= 1'b0;
        else if (en)
            r_d_v <= r_c_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc_px <= r_c_px;
            r_d_px  <= r_cc_px;
            r_d_k   <= r_c_k;
            r_d_t   <= r_c_t;
            r_d_t2  <= r_c_t2;
            r_d_hi  <= 36'(r_c_t2[35:18]) * 36'(r_c_t);
            r_d_lo  <= 36'(r_c_t2[17:0]) * 36'(r_c_t);
        end
    end

    // stage E: weights
    logic [53:0]        t3;
    logic signed [58:0] s3, s2t, s1t, num [4];
    logic signed [58:0] rw [4];
    logic signed [19:0] w_e [4];

    always_comb begin
        t3  = {r_d_hi, 18'b0} + 54'(r_d_lo);
        s3  = $signed({5'b0, t3});
        s2t = $signed({5'b0, r_d_t2, 18'b0});
        s1t = $signed({5'b0, r_d_t, 36'b0});
        num[0] = (s2t <<< 1) - s3 - s1t;
        num[1] = (s3 <<< 1) + s3 - (s2t <<< 2) - s2t + C_2T3;
        num[2] = (s2t <<< 2) + s1t - (s3 <<< 1) - s3;
        num[3] = s3 - s2t;
        for (int q = 0; q < 4; q++)
            rw[q] = (num[q] + C_HALF) >>> 37;
        unique case (r_method)
            MTH_NEAREST: begin
                w_e[0] = '0;
                w_e[1] = C_WONE;
                w_e[2] = '0;
                w_e[3] = '0;
            end
            MTH_LINEAR: begin
                w_e[0] = '0;
                w_e[1] = C_WONE - $signed({2'b00, r_d_t});
                w_e[2] = $signed({2'b00, r_d_t});
                w_e[3] = '0;
            end
            MTH_CUBIC, MTH_CUBIC_ALT: begin
                for (int q = 0; q < 4; q++)
                    w_e[q] = rw[q][19:0];
            end
        endcase
    end

    logic               r_e_v;
    logic [11:0]        r_e_k;
    logic signed [19:0] r_e_w [4];
    logic [7:0]         r_e_px [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_e_v <= 1'b0;
        else if (en)
            r_e_v <= r_d_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_k  <= r_d_k;
            r_e_w  <= w_e;
            r_e_px <= r_d_px;
        end
    end

    // stage F: products
    logic               r_f_v;
    logic [11:0]        r_f_k;
    logic signed [28:0] r_f_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_f_v <= 1'b0;
        else if (en)
            r_f_v <= r_e_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_k <= r_e_k;
            for (int q = 0; q < 4; q++)
                r_f_p[q] <= $signed({1'b0, r_e_px[q]}) * r_e_w[q];
        end
    end

    // stage G: sum, round half up, saturate
    logic signed [30:0] acc;
    logic signed [12:0] res;
    logic [7:0]         g_val;
    logic               g_sat;
    logic               g_clip;
    logic               g_v;

    always_comb begin
        acc = 31'(r_f_p[0]) + 31'(r_f_p[1]) + 31'(r_f_p[2]) + 31'(r_f_p[3]) + C_RND;
        res = 13'(acc >>> 18);
        if (res < 0) begin
            g_val = 8'd0;
            g_sat = 1'b1;
        end else if (res > 13'sd255) begin
            g_val = 8'd255;
            g_sat = 1'b1;
        end else begin
            g_val = res[7:0];
            g_sat = 1'b0;
        end
        g_clip = g_sat && r_method[1];
        g_v    = r_f_v && en;
    end

    // output register with skid
    logic        r_out_v;
    logic [7:0]  r_out_val;
    logic [11:0] r_out_k;
    logic        r_out_clip;
    logic [7:0]  r_skid_val;
    logic [11:0] r_skid_k;
    logic        r_skid_clip;
    logic        out_free;

    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || g_v;
            r_skid_v <= 1'b0;
        end else if (g_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out_val  <= r_skid_val;
                r_out_k    <= r_skid_k;
                r_out_clip <= r_skid_clip;
            end else begin
                r_out_val  <= g_val;
                r_out_k    <= r_f_k;
                r_out_clip <= g_clip;
            end
        end else if (g_v) begin
            r_skid_val  <= g_val;
            r_skid_k    <= r_f_k;
            r_skid_clip <= g_clip;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_sample_value  = r_out_val;
    assign o_sample_number = r_out_k;
    assign o_clipped       = r_out_clip;

    `LRI_ASSERT_NOW(a_skid_behind_out, r_skid_v, r_out_v, "skid word without output word")
    `LRI_ASSERT_NEXT(a_skid_holds, r_skid_v && r_out_v && i_out_stall, r_skid_v,
        "skid word dropped while stalled")
    `LRI_ASSERT_NOW(a_clip_cubic_only, r_out_v && r_out_clip,
        r_method == MTH_CUBIC || r_method == MTH_CUBIC_ALT, "clip flag outside cubic mode")
    `LRI_ASSERT_NOW(a_clip_at_rail, r_out_v && r_out_clip,
        r_out_val == 8'd0 || r_out_val == 8'd255, "clip flag with value off the rails")

endmodule

// File: tb/tb_line_resampler_interp.sv
// Testbench for line_resampler_interp: directed and random writes and sample requests,
// checked against a behavioural scaler model kept inside the bench. Depends on lri_pkg.
`timescale 1ns / 1ps
module tb_line_resampler_interp;
    import lri_pkg::*;

    localparam int    LMAX = 1024;
    localparam int    FRAC = 16;
    localparam int    WB   = 18;
    localparam longint WONE = 64'sd1 << WB;

    typedef struct packed {
        logic [7:0]  value;
        logic [11:0] number;
        logic        clip;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = 1'b0;
    logic [9:0]  i_pixel_index = '0;
    logic [7:0]  i_pixel_value = '0;
    logic [11:0] i_sample_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_sample_value;
    logic [11:0] o_sample_number;
    logic        o_clipped;

    line_resampler_interp i_dut (.*);

    // shadow of the block's state
    logic [7:0]  pix_mem [LMAX];
    logic [10:0] len_reg = LINE_LENGTH_RST;
    logic [19:0] step_reg = STEP_RATIO_RST;
    t_method     mth_reg = MTH_CUBIC;

    t_sample     pending_samples[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          words_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Timeout with %0d samples outstanding", pending_samples.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint eff_len();
        longint n;
        n = len_reg;
        if (n < 4) n = 4;
        if (n > LMAX) n = LMAX;
        return n;
    endfunction

    // mirror about the edge sample
    function automatic longint pix_at(longint j, longint n);
        if (j < 0) j = -j;
        if (j > n - 1) j = 2 * (n - 1) - j;
        if (j < 0) j = 0;
        if (j > n - 1) j = n - 1;
        return pix_mem[j];
    endfunction

    function automatic longint q18_weight(longint num);
        longint biased;
        biased = num + 2 * WONE * WONE * WONE + WONE * WONE;
        return (biased >>> (2 * WB + 1)) - WONE;
    endfunction

    function automatic longint q18_round(longint acc);
        return ((acc + 1024 * WONE + WONE / 2) >>> WB) - 1024;
    endfunction

    function automatic t_sample interp_sample(logic [11:0] k);
        longint n, i, t, res, acc, t2, t3, wm1, w0, w1, w2;
        longint unsigned p;
        t_sample s;
        n = eff_len();
        p = longint'(k) * longint'(step_reg);
        i = longint'(p >> FRAC);
        t = longint'(p & ((64'd1 << FRAC) - 1)) << (WB - FRAC);
        if (i >= n) begin
            i = n - 1;
            t = 0;
        end
        s.clip = 1'b0;
        if (mth_reg == MTH_NEAREST) begin
            res = pix_at(i, n);
        end else if (mth_reg == MTH_LINEAR) begin
            acc = pix_at(i, n) * (WONE - t) + pix_at(i + 1, n) * t;
            res = q18_round(acc);
        end else begin
            t2 = t * t;
            t3 = t2 * t;
            wm1 = q18_weight(-t3 + 2 * t2 * WONE - t * WONE * WONE);
            w0  = q18_weight(3 * t3 - 5 * t2 * WONE + 2 * WONE * WONE * WONE);
            w1  = q18_weight(-3 * t3 + 4 * t2 * WONE + t * WONE * WONE);
            w2  = q18_weight(t3 - t2 * WONE);
            acc = pix_at(i - 1, n) * wm1 + pix_at(i, n) * w0
                + pix_at(i + 1, n) * w1 + pix_at(i + 2, n) * w2;
            res = q18_round(acc);
            if (res < 0 || res > 255) s.clip = 1'b1;
        end
        if (res < 0) res = 0;
        if (res > 255) res = 255;
        s.value = res[7:0];
        s.number = k;
        return s;
    endfunction

    // result side: random stall, compare each accepted word
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected sample %0d value %0d", o_sample_number, o_sample_value);
            end else begin
                exp_s = pending_samples.pop_front();
                if (o_sample_value !== exp_s.value || o_sample_number !== exp_s.number
                        || o_clipped !== exp_s.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Sample mismatch: exp k=%0d v=%0d c=%0b, got k=%0d v=%0d c=%0b",
                                 exp_s.number, exp_s.value, exp_s.clip,
                                 o_sample_number, o_sample_value, o_clipped);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // send one word; called at a rising edge, returns at the edge that accepts it
    task automatic send_word(logic mode, logic [9:0] idx, logic [7:0] val, logic [11:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_pixel_index <= idx;
        i_pixel_value <= val;
        i_sample_index <= k;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        words_sent++;
        if (!mode) pix_mem[idx] = val;
        else pending_samples.push_back(interp_sample(k));
    endtask

    task automatic request(logic [11:0] k);
        send_word(1'b1, 10'($urandom), 8'($urandom), k);
    endtask

    // hold until every sample is back and the pipeline has drained
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [19:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_LENGTH: len_reg = data[10:0];
            CFG_STEP_RATIO:  step_reg = data;
            CFG_METHOD:      mth_reg = t_method'(data[1:0]);
            default: ;
        endcase
    endtask

    task automatic set_scaler(logic [10:0] len, logic [19:0] step, t_method m);
        write_reg(CFG_LINE_LENGTH, {9'd0, len});
        write_reg(CFG_STEP_RATIO, step);
        write_reg(CFG_METHOD, {18'd0, m});
    endtask

    // fill the whole store so no request can touch an unwritten pixel
    task automatic test_fill_store();
        for (int j = 0; j < LMAX; j++)
            send_word(1'b0, j[9:0], (j < 32) ? ((j % 2) ? 8'd255 : 8'd0) : 8'($urandom), '0);
    endtask

    task automatic test_directed();
        request(12'd0);
        request(12'd4095);
        request(12'd3);
        set_scaler(11'd16, 20'd24576, MTH_CUBIC);
        for (int k = 0; k < 6; k++) request(k[11:0]);
        set_scaler(11'd8, 20'd40000, MTH_LINEAR);
        request(12'd1);
        request(12'd7);
        request(12'd4095);
        set_scaler(11'd2, 20'd0, MTH_NEAREST);
        request(12'd0);
        request(12'd4095);
        set_scaler(11'd2047, 20'd1048575, MTH_CUBIC_ALT);
        request(12'd0);
        request(12'd1);
        request(12'd4095);
        set_scaler(11'd1024, 20'd1, MTH_CUBIC);
        request(12'd4095);
        write_reg(CFG_UNUSED, 20'hFFFFF);
        set_scaler(11'd4, 20'd32768, MTH_CUBIC);
        request(12'd5);
        request(12'd7);
    endtask

    task automatic test_random(int words);
        int r;
        for (int w = 0; w < words; w++) begin
            if (w % 90 == 0) begin
                r = $urandom_range(9);
                set_scaler((r < 3) ? 11'($urandom_range(40, 4)) :
                           (r < 5) ? 11'($urandom) : 11'($urandom_range(1024, 4)),
                           (r == 9) ? 20'($urandom) : 20'($urandom_range(200000, 1)),
                           t_method'(2'($urandom_range(3))));
            end
            if ($urandom_range(99) < 25)
                send_word(1'b0, 10'($urandom), 8'($urandom), 12'($urandom));
            else
                request(12'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_store();
        test_directed();
        send_idle_pct = 29;
        recv_stall_pct = 47;
        test_random(190);
        drain();
        send_idle_pct = 47;
        recv_stall_pct = 29;
        test_random(190);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(190);
        drain();
        $display("Sent %0d words, checked %0d samples over nearest, linear and cubic,",
                 words_sent, results_seen);
        $display("with edge lengths, zero and maximum steps and random back-pressure.");
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/lri_pkg.sv
hdl/line_resampler_interp.sv
tb/tb_line_resampler_interp.sv
